### design/sev_pkg.sv
// Shared types and constants of the eddy viscosity stencil block.
`timescale 1ns / 1ps

package sev_pkg;

  // One voxel request of the raster stream.
  typedef struct packed {
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic signed [31:0] vel_w;
    logic [15:0]        cell_coef;
    logic               block_end;
  } sev_in_t;

  // One result per interior cell.
  typedef struct packed {
    logic [30:0]        eddy_viscosity;
    logic signed [31:0] lap_u;
    logic signed [31:0] lap_v;
    logic signed [31:0] lap_w;
    logic               last_cell;
  } sev_out_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_CS_SQUARED     = 8'd0;
  localparam logic [7:0] CFG_SPACING        = 8'd1;
  localparam logic [7:0] CFG_INV_SPACING_SQ = 8'd2;
  localparam logic [7:0] CFG_USE_CELL_COEF  = 8'd3;

  // Register reset values.
  localparam logic [15:0] CS_SQUARED_RST     = 16'd2621;
  localparam logic [31:0] SPACING_RST        = 32'd65536;
  localparam logic [31:0] INV_SPACING_SQ_RST = 32'd65536;

  // History word: coefficient and the three velocities.
  localparam int WORD_W = 112;

  // Shared digit-serial multiplier.
  localparam int MUL_AW    = 48;
  localparam int MUL_BW    = 36;
  localparam int MUL_DW    = 9;
  localparam int MUL_PW    = 84;
  localparam int MUL_STEPS = 4;
  localparam int MUL_CW    = 2;

  // Strain sum, root and Laplacian magnitude widths.
  localparam int STRAIN_W = 70;
  localparam int ROOT_W   = 35;
  localparam int REM_W    = 38;
  localparam int SQ_W     = 34;
  localparam int LMAG_W   = 35;

  // Multiply request from the sequencer.
  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

endpackage

### design/sev_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module sev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sev_mul.sv
// Shared digit-serial multiplier, nine bits of the second operand per cycle.
`timescale 1ns / 1ps

module sev_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  sev_pkg::mul_req_t         req,
  output logic                      done,
  output logic [sev_pkg::MUL_PW-1:0] prod
);

  logic                               busy;
  logic [sev_pkg::MUL_CW-1:0]         cnt;
  logic [sev_pkg::MUL_AW-1:0]         a_r;
  logic [sev_pkg::MUL_BW-1:0]         b_r;
  logic [sev_pkg::MUL_PW-1:0]         acc;
  logic [sev_pkg::MUL_AW+sev_pkg::MUL_DW-1:0] pp;

  // Partial product of the top digit.
  assign pp   = a_r * b_r[sev_pkg::MUL_BW-1 -: sev_pkg::MUL_DW];
  assign prod = acc;

  // Control: busy while the digits are processed, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sev_pkg::MUL_CW'(sev_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the accumulator by one digit and add the partial product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[sev_pkg::MUL_PW-sev_pkg::MUL_DW-1:0], {sev_pkg::MUL_DW{1'b0}}} +
             sev_pkg::MUL_PW'(pp);
      b_r <= {b_r[sev_pkg::MUL_BW-sev_pkg::MUL_DW-1:0], {sev_pkg::MUL_DW{1'b0}}};
    end
  end

endmodule

### design/smagorinsky_eddy_viscosity_stencil_top.sv
// Top level of the Smagorinsky eddy viscosity 7-point stencil block.
//
// Usage: voxels of a halo-padded block arrive on the in channel in raster
// order (x fastest, then y, then z), one request per voxel. Each voxel is
// written into a history RAM of 2*BLOCK_X*BLOCK_Y+1 words. For every interior
// cell one result leaves on the out channel, produced while the voxel one
// plane above it is handled; other voxels produce no result.
// Processing: a voxel that completes no interior cell leaves the block idle. One
// that does passes through the neighbor reads from the single read port of the
// history RAM, eleven passes through the shared digit-serial multiplier and the
// bit-serial square root, and no voxel is accepted until it is done. A finished
// result waits in the output register, and the next voxel is accepted while it
// waits; when the receiver stalls and a second result is ready, the block holds
// it and accepts nothing until the register frees. Reset clears the position,
// the control state and the output valid, and restores the configuration
// registers. Configuration writes on the cfg channel are always ready and take
// effect at once; write only while idle.
`timescale 1ns / 1ps

module smagorinsky_eddy_viscosity_stencil_top #(
  parameter int BLOCK_X = 8,
  parameter int BLOCK_Y = 8,
  parameter int BLOCK_Z = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sev_pkg::sev_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sev_pkg::sev_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int PLANE = BLOCK_X * BLOCK_Y;
  localparam int HIST  = 2 * PLANE + 1;
  localparam int AW    = $clog2(HIST);
  localparam int AW1   = AW + 1;
  localparam int XW    = $clog2(BLOCK_X);
  localparam int YW    = $clog2(BLOCK_Y);
  localparam int ZW    = $clog2(BLOCK_Z);
  localparam int XW1   = XW + 1;
  localparam int YW1   = YW + 1;
  localparam int ZW1   = ZW + 1;

  // Distances back from the newest voxel.
  localparam logic [AW:0] K_E = AW1'(PLANE - 1);
  localparam logic [AW:0] K_W = AW1'(PLANE + 1);
  localparam logic [AW:0] K_N = AW1'(PLANE - BLOCK_X);
  localparam logic [AW:0] K_S = AW1'(PLANE + BLOCK_X);
  localparam logic [AW:0] K_F = AW1'(2 * PLANE);
  localparam logic [AW:0] K_C = AW1'(PLANE);
  localparam logic [AW:0] HIST_X = AW1'(HIST);

  // Neighbor slots in read order.
  localparam logic [2:0] SL_E = 3'd0;
  localparam logic [2:0] SL_W = 3'd1;
  localparam logic [2:0] SL_N = 3'd2;
  localparam logic [2:0] SL_S = 3'd3;
  localparam logic [2:0] SL_F = 3'd4;
  localparam logic [2:0] SL_C = 3'd5;
  localparam logic [2:0] RD_END = 3'd6;

  // Multiply operations in sequence.
  localparam logic [3:0] OP_SQ0  = 4'd0;
  localparam logic [3:0] OP_SQ1  = 4'd1;
  localparam logic [3:0] OP_SQ2  = 4'd2;
  localparam logic [3:0] OP_SQ3  = 4'd3;
  localparam logic [3:0] OP_SQ4  = 4'd4;
  localparam logic [3:0] OP_SQ5  = 4'd5;
  localparam logic [3:0] OP_CSP  = 4'd6;
  localparam logic [3:0] OP_EDDY = 4'd7;
  localparam logic [3:0] OP_LAPU = 4'd8;
  localparam logic [3:0] OP_LAPV = 4'd9;
  localparam logic [3:0] OP_LAPW = 4'd10;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_MGO   = 7'b0001000,
    S_MWAIT = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] cs_squared;
  logic [31:0] spacing;
  logic [31:0] inv_spacing_sq;
  logic        use_cell_coef;

  // Position and history write pointer.
  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [ZW-1:0] pos_z;
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_inc;
  logic          x_last, y_last, z_last;
  logic          interior;
  logic          accept;

  // Per-item working registers.
  logic [AW-1:0]      base;
  logic               last_r;
  logic [2:0]         rcnt;
  logic [2:0]         rslot;
  logic [AW:0]        rd_k;
  logic [AW:0]        rd_sum;
  logic [AW-1:0]      raddr;
  logic [sev_pkg::WORD_W-1:0] rdata;
  logic signed [31:0] cur [3];
  logic signed [31:0] nb [3][6];
  logic [15:0]        cen_coef;

  logic signed [32:0] dd [3][3];
  logic signed [33:0] tm [6];
  logic signed [35:0] ls [3];
  logic [sev_pkg::SQ_W-1:0]   sqm [6];
  logic [sev_pkg::LMAG_W-1:0] lmag [3];
  logic                       lneg [3];

  logic [3:0]                     op;
  logic [sev_pkg::STRAIN_W-1:0]   strain;
  logic [sev_pkg::STRAIN_W-1:0]   strain_new;
  logic [sev_pkg::STRAIN_W-1:0]   rad;
  logic [sev_pkg::REM_W-1:0]      rem;
  logic [sev_pkg::REM_W-1:0]      remx;
  logic [sev_pkg::REM_W-1:0]      trial;
  logic [sev_pkg::ROOT_W-1:0]     root;
  logic [5:0]                     scnt;
  logic [47:0]                    csp;
  logic [30:0]                    eddy_r;
  logic [31:0]                    lap_r [3];

  sev_pkg::mul_req_t              mreq;
  logic                           mdone;
  logic [sev_pkg::MUL_PW-1:0]     mprod;
  logic [15:0]                    coef_sel;
  logic                           out_load;

  // Saturate a Laplacian product to the 32-bit signed range.
  function automatic logic [31:0] lap_sat(input logic [sev_pkg::MUL_PW-1:0] p,
                                          input logic neg);
    logic [67:0] q;
    logic [67:0] lim;
    q   = p[sev_pkg::MUL_PW-1:16];
    lim = neg ? 68'h80000000 : 68'h7FFFFFFF;
    if (q > lim) begin
      q = lim;
    end
    return neg ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Position decode.
  assign x_last   = (pos_x == XW'(BLOCK_X - 1));
  assign y_last   = (pos_y == YW'(BLOCK_Y - 1));
  assign z_last   = (pos_z == ZW'(BLOCK_Z - 1));
  assign wp_inc   = (wp == AW'(HIST - 1)) ? '0 : wp + 1'b1;
  assign interior = ({1'b0, pos_z} >= ZW1'(2)) &&
                    ({1'b0, pos_x} >= XW1'(1)) && ({1'b0, pos_x} <= XW1'(BLOCK_X - 2)) &&
                    ({1'b0, pos_y} >= YW1'(1)) && ({1'b0, pos_y} <= YW1'(BLOCK_Y - 2));

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_squared     <= sev_pkg::CS_SQUARED_RST;
      spacing        <= sev_pkg::SPACING_RST;
      inv_spacing_sq <= sev_pkg::INV_SPACING_SQ_RST;
      use_cell_coef  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sev_pkg::CFG_CS_SQUARED:     cs_squared     <= cfg_data[15:0];
        sev_pkg::CFG_SPACING:        spacing        <= cfg_data;
        sev_pkg::CFG_INV_SPACING_SQ: inv_spacing_sq <= cfg_data;
        sev_pkg::CFG_USE_CELL_COEF:  use_cell_coef  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Raster position and history pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      wp    <= '0;
    end else if (accept) begin
      if (in_data.block_end || (x_last && y_last && z_last)) begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        wp    <= '0;
      end else begin
        wp <= wp_inc;
        if (!x_last) begin
          pos_x <= pos_x + 1'b1;
        end else begin
          pos_x <= '0;
          if (!y_last) begin
            pos_y <= pos_y + 1'b1;
          end else begin
            pos_y <= '0;
            pos_z <= pos_z + 1'b1;
          end
        end
      end
    end
  end

  // Neighbor read address: base minus distance, modulo the history depth.
  assign rslot = rcnt - 3'd1;
  always_comb begin
    case (rcnt)
      SL_E:    rd_k = K_E;
      SL_W:    rd_k = K_W;
      SL_N:    rd_k = K_N;
      SL_S:    rd_k = K_S;
      SL_F:    rd_k = K_F;
      default: rd_k = K_C;
    endcase
    if ({1'b0, base} >= rd_k) begin
      rd_sum = {1'b0, base} - rd_k;
    end else begin
      rd_sum = {1'b0, base} + HIST_X - rd_k;
    end
    raddr = rd_sum[AW-1:0];
  end

  sev_ram #(
    .WIDTH(sev_pkg::WORD_W),
    .DEPTH(HIST)
  ) u_hist (
    .clk  (clk),
    .we   (accept),
    .waddr(wp),
    .wdata({in_data.cell_coef, in_data.vel_w, in_data.vel_v, in_data.vel_u}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Central differences, strain terms and Laplacian sums.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dd[a][0] = 33'(nb[a][SL_E]) - 33'(nb[a][SL_W]);
      dd[a][1] = 33'(nb[a][SL_N]) - 33'(nb[a][SL_S]);
      dd[a][2] = 33'(cur[a]) - 33'(nb[a][SL_F]);
      ls[a] = 36'(nb[a][SL_E]) + 36'(nb[a][SL_W]) + 36'(nb[a][SL_N]) +
              36'(nb[a][SL_S]) + 36'(cur[a]) + 36'(nb[a][SL_F]) -
              (36'(nb[a][SL_C]) <<< 2) - (36'(nb[a][SL_C]) <<< 1);
    end
    tm[0] = 34'(dd[0][0]);
    tm[1] = 34'(dd[1][1]);
    tm[2] = 34'(dd[2][2]);
    tm[3] = 34'(dd[0][1]) + 34'(dd[1][0]);
    tm[4] = 34'(dd[0][2]) + 34'(dd[2][0]);
    tm[5] = 34'(dd[2][1]) + 34'(dd[1][2]);
  end

  // Multiplier operand selection.
  assign coef_sel = use_cell_coef ? cen_coef : cs_squared;
  always_comb begin
    mreq.start = (state == S_MGO);
    case (op)
      OP_SQ0:  begin mreq.a = 48'(sqm[0]); mreq.b = 36'(sqm[0]); end
      OP_SQ1:  begin mreq.a = 48'(sqm[1]); mreq.b = 36'(sqm[1]); end
      OP_SQ2:  begin mreq.a = 48'(sqm[2]); mreq.b = 36'(sqm[2]); end
      OP_SQ3:  begin mreq.a = 48'(sqm[3]); mreq.b = 36'(sqm[3]); end
      OP_SQ4:  begin mreq.a = 48'(sqm[4]); mreq.b = 36'(sqm[4]); end
      OP_SQ5:  begin mreq.a = 48'(sqm[5]); mreq.b = 36'(sqm[5]); end
      OP_CSP:  begin mreq.a = 48'(spacing); mreq.b = 36'(coef_sel); end
      OP_EDDY: begin mreq.a = csp; mreq.b = 36'(root); end
      OP_LAPU: begin mreq.a = 48'(lmag[0]); mreq.b = 36'(inv_spacing_sq); end
      OP_LAPV: begin mreq.a = 48'(lmag[1]); mreq.b = 36'(inv_spacing_sq); end
      OP_LAPW: begin mreq.a = 48'(lmag[2]); mreq.b = 36'(inv_spacing_sq); end
      default: begin mreq.a = '0; mreq.b = '0; end
    endcase
  end

  sev_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .done(mdone),
    .prod(mprod)
  );

  // Strain accumulation: the three diagonal squares count twice.
  assign strain_new = (op <= OP_SQ2) ? strain + {mprod[68:0], 1'b0}
                                     : strain + mprod[sev_pkg::STRAIN_W-1:0];

  // One root bit per cycle: trial subtract on the partial remainder.
  assign remx  = {rem[sev_pkg::REM_W-3:0], rad[sev_pkg::STRAIN_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rcnt  <= '0;
      op    <= OP_SQ0;
      scnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && interior) begin
            rcnt  <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == RD_END) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          op    <= OP_SQ0;
          state <= S_MGO;
        end
        S_MGO: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mdone) begin
            if (op == OP_SQ5) begin
              scnt  <= '0;
              state <= S_SQRT;
            end else if (op == OP_LAPW) begin
              state <= S_FIN;
            end else begin
              op    <= op + 4'd1;
              state <= S_MGO;
            end
          end
        end
        S_SQRT: begin
          scnt <= scnt + 6'd1;
          if (scnt == 6'(sev_pkg::ROOT_W - 1)) begin
            op    <= OP_CSP;
            state <= S_MGO;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item capture and neighbor reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      base   <= wp;
      last_r <= ({1'b0, pos_x} == XW1'(BLOCK_X - 2)) &&
                ({1'b0, pos_y} == YW1'(BLOCK_Y - 2)) &&
                ({1'b0, pos_z} == ZW1'(BLOCK_Z - 1));
      cur[0] <= in_data.vel_u;
      cur[1] <= in_data.vel_v;
      cur[2] <= in_data.vel_w;
    end
    if (state == S_READ && rcnt != 3'd0) begin
      nb[0][rslot] <= rdata[31:0];
      nb[1][rslot] <= rdata[63:32];
      nb[2][rslot] <= rdata[95:64];
      if (rslot == SL_C) begin
        cen_coef <= rdata[111:96];
      end
    end
  end

  // Difference stage registers, multiply results and square root steps.
  always_ff @(posedge clk) begin
    if (state == S_DIFF) begin
      strain <= '0;
      for (int i = 0; i < 6; i++) begin
        sqm[i] <= tm[i][33] ? 34'(-tm[i]) : 34'(tm[i]);
      end
      for (int a = 0; a < 3; a++) begin
        lmag[a] <= ls[a][35] ? 35'(-ls[a]) : 35'(ls[a]);
        lneg[a] <= ls[a][35];
      end
    end else if (state == S_MWAIT && mdone) begin
      case (op)
        OP_SQ0, OP_SQ1, OP_SQ2, OP_SQ3, OP_SQ4: strain <= strain_new;
        OP_SQ5: begin
          rad  <= strain_new;
          rem  <= '0;
          root <= '0;
        end
        OP_CSP:  csp <= mprod[47:0];
        OP_EDDY: eddy_r <= (mprod[83:64] != 20'd0) ? 31'h7FFFFFFF : mprod[63:33];
        OP_LAPU: lap_r[0] <= lap_sat(mprod, lneg[0]);
        OP_LAPV: lap_r[1] <= lap_sat(mprod, lneg[1]);
        OP_LAPW: lap_r[2] <= lap_sat(mprod, lneg[2]);
        default: ;
      endcase
    end else if (state == S_SQRT) begin
      rad <= {rad[sev_pkg::STRAIN_W-3:0], 2'b00};
      if (remx >= trial) begin
        rem  <= remx - trial;
        root <= {root[sev_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= remx;
        root <= {root[sev_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.eddy_viscosity <= eddy_r;
      out_data.lap_u          <= lap_r[0];
      out_data.lap_v          <= lap_r[1];
      out_data.lap_w          <= lap_r[2];
      out_data.last_cell      <= last_r;
    end
  end

endmodule

### design/sev_checker.sv
// Port-level checks of the eddy viscosity stencil block, bound to the top level.
`timescale 1ns / 1ps

module sev_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sev_pkg::sev_out_t out_data
);

  // A stalled request keeps waiting.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input request dropped before acceptance");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A result never appears right after a request is accepted.
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared directly after an accepted request");

  // The block stops taking requests only when it has just accepted one.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("ready dropped without an accepted request");

endmodule

bind smagorinsky_eddy_viscosity_stencil_top sev_port_checker u_sev_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
